FILE: sv/qdw_pkg.sv
// ----------------------------------------------------------------------------
// qdw_pkg
// Shared types, constants and the step table of the quadrature decoder.
// ----------------------------------------------------------------------------
package qdw_pkg;

  localparam int CNT_W = 32;
  localparam int MS_PER_S = 1000;
  localparam logic [1:0] PIN_MASK = 2'h3;

  localparam int DIV_DIGITS = 6;
  localparam int DIV_BITS = 42;
  localparam int DIV_STEPS = DIV_BITS / DIV_DIGITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_SAT,
    S_PUB
  } state_t;

  typedef struct packed {
    logic exec;
    logic mul_load;
    logic div_start;
    logic rate_write;
    logic sel;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // x4 step: +1 forward, -1 reverse, 0 for no change or a double step
  function automatic logic [1:0] step_of(input logic [1:0] prev, input logic [1:0] now);
    logic [3:0] idx;
    logic [1:0] step;
    idx = {prev & PIN_MASK, now & PIN_MASK};
    case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'b01;
      4'd1, 4'd7, 4'd8, 4'd14:  step = 2'b11;
      default:                  step = 2'b00;
    endcase
    return step;
  endfunction

endpackage

FILE: sv/qdw_if.sv
// ----------------------------------------------------------------------------
// qdw_if
// Valid/ready channels for operation items and count/speed results.
// ----------------------------------------------------------------------------
interface qdw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       motor;
  logic [1:0] pins_motor0;
  logic [1:0] pins_motor1;

  modport source (output valid, op, motor, pins_motor0, pins_motor1, input ready);
  modport sink (input valid, op, motor, pins_motor0, pins_motor1, output ready);
endinterface

interface qdw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count_motor0;
  logic signed [31:0] count_motor1;
  logic signed [31:0] speed_motor0;
  logic signed [31:0] speed_motor1;

  modport source (output valid, count_motor0, count_motor1, speed_motor0, speed_motor1,
                  input ready);
  modport sink (input valid, count_motor0, count_motor1, speed_motor0, speed_motor1,
                output ready);
endinterface

FILE: sv/qdw_div.sv
// ----------------------------------------------------------------------------
// qdw_div
// Multi-cycle unsigned divider by the window length, several digits a cycle.
// ----------------------------------------------------------------------------
module qdw_div #(
  parameter int WINDOW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [qdw_pkg::DIV_BITS-1:0] dividend,
  output logic [qdw_pkg::DIV_BITS-1:0] quotient,
  output logic                         done
);
  import qdw_pkg::*;

  localparam int REM_W = $clog2(WINDOW + 1);

  logic [DIV_BITS-1:0]  work;
  logic [DIV_BITS-1:0]  work_next;
  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     rem_next;
  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;

  always_comb begin
    logic [REM_W:0]      trial;
    logic [DIV_BITS-1:0] w;
    logic [REM_W-1:0]    r;
    w = work;
    r = rem;
    trial = '0;
    for (int k = 0; k < DIV_DIGITS; k++) begin
      trial = {r, w[DIV_BITS-1]};
      w = {w[DIV_BITS-2:0], 1'b0};
      if (trial >= (REM_W+1)'(WINDOW)) begin
        trial = trial - (REM_W+1)'(WINDOW);
        w[0] = 1'b1;
      end
      r = trial[REM_W-1:0];
    end
    work_next = w;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

FILE: sv/qdw_dp.sv
// ----------------------------------------------------------------------------
// qdw_dp
// Counts, speeds, pin history, count history ring and speed arithmetic.
// ----------------------------------------------------------------------------
module qdw_dp #(
  parameter int WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  qdw_pkg::cmd_t      cmd,
  output qdw_pkg::status_t   status,
  input  logic [1:0]         op,
  input  logic               motor,
  input  logic [1:0]         pins_motor0,
  input  logic [1:0]         pins_motor1,
  output logic signed [31:0] count_motor0,
  output logic signed [31:0] count_motor1,
  output logic signed [31:0] speed_motor0,
  output logic signed [31:0] speed_motor1
);
  import qdw_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  op_t                 op_code;
  logic [CNT_W-1:0]    position [2];
  logic [CNT_W-1:0]    rate [2];
  logic [1:0]          prev_pins [2];
  logic [SLOT_W-1:0]   ring_slot;
  logic [SLOT_W-1:0]   slot_next;
  logic [WINDOW-1:0]   hist_ok0;
  logic [WINDOW-1:0]   hist_ok1;
  logic [CNT_W-1:0]    hist0 [WINDOW];
  logic [CNT_W-1:0]    hist1 [WINDOW];
  logic [CNT_W-1:0]    rd0;
  logic [CNT_W-1:0]    rd1;
  logic                rd_ok0;
  logic                rd_ok1;
  logic                hist_we;
  logic [1:0]          step0;
  logic [1:0]          step1;
  logic [CNT_W-1:0]    old_count;
  logic [CNT_W-1:0]    diff;
  logic [CNT_W-1:0]    mag;
  logic [DIV_BITS-1:0] product;
  logic [DIV_BITS-1:0] mul_q;
  logic                mul_neg;
  logic [DIV_BITS-1:0] quo;
  logic [CNT_W-1:0]    sat_value;

  assign op_code = op_t'(op);
  assign hist_we = cmd.exec && (op_code == OP_TICK);
  assign slot_next = (ring_slot == SLOT_W'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
  assign step0 = step_of(prev_pins[0], pins_motor0);
  assign step1 = step_of(prev_pins[1], pins_motor1);

  always_ff @(posedge clk) begin
    if (rst) begin
      position[0]  <= '0;
      position[1]  <= '0;
      rate[0]      <= '0;
      rate[1]      <= '0;
      prev_pins[0] <= '0;
      prev_pins[1] <= '0;
      ring_slot    <= '0;
      hist_ok0     <= '0;
      hist_ok1     <= '0;
    end else begin
      if (cmd.exec) begin
        case (op_code)
          OP_SAMPLE: begin
            position[0]  <= position[0] + {{(CNT_W-2){step0[1]}}, step0};
            position[1]  <= position[1] + {{(CNT_W-2){step1[1]}}, step1};
            prev_pins[0] <= pins_motor0 & PIN_MASK;
            prev_pins[1] <= pins_motor1 & PIN_MASK;
          end
          OP_TICK: begin
            ring_slot           <= slot_next;
            hist_ok0[ring_slot] <= 1'b1;
            hist_ok1[ring_slot] <= 1'b1;
          end
          OP_CLEAR: begin
            if (motor) begin
              position[1] <= '0;
              rate[1]     <= '0;
              hist_ok1    <= '0;
            end else begin
              position[0] <= '0;
              rate[0]     <= '0;
              hist_ok0    <= '0;
            end
          end
          OP_INIT: begin
            position[0]  <= '0;
            position[1]  <= '0;
            rate[0]      <= '0;
            rate[1]      <= '0;
            hist_ok0     <= '0;
            hist_ok1     <= '0;
            prev_pins[0] <= pins_motor0 & PIN_MASK;
            prev_pins[1] <= pins_motor1 & PIN_MASK;
            ring_slot    <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.rate_write) begin
        rate[cmd.sel] <= sat_value;
      end
    end
  end

  // history ring, old entry read out as the new one goes in
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist0[ring_slot] <= position[0];
      hist1[ring_slot] <= position[1];
      rd0              <= hist0[ring_slot];
      rd1              <= hist1[ring_slot];
      rd_ok0           <= hist_ok0[ring_slot];
      rd_ok1           <= hist_ok1[ring_slot];
    end
  end

  always_comb begin
    if (cmd.sel) begin
      old_count = rd_ok1 ? rd1 : '0;
    end else begin
      old_count = rd_ok0 ? rd0 : '0;
    end
    diff = position[cmd.sel] - old_count;
    mag = diff[CNT_W-1] ? (~diff + 1'b1) : diff;
    product = DIV_BITS'(mag) * DIV_BITS'(MS_PER_S);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_q   <= product;
      mul_neg <= diff[CNT_W-1];
    end
  end

  qdw_div #(
    .WINDOW(WINDOW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mul_q),
    .quotient (quo),
    .done     (status.div_done)
  );

  always_comb begin
    if (mul_neg) begin
      if ((|quo[DIV_BITS-1:CNT_W]) || (quo[CNT_W-1] && (|quo[CNT_W-2:0]))) begin
        sat_value = 32'h8000_0000;
      end else begin
        sat_value = ~quo[CNT_W-1:0] + 1'b1;
      end
    end else if (|quo[DIV_BITS-1:CNT_W-1]) begin
      sat_value = 32'h7FFF_FFFF;
    end else begin
      sat_value = quo[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      count_motor0 <= $signed(position[0]);
      count_motor1 <= $signed(position[1]);
      speed_motor0 <= $signed(rate[0]);
      speed_motor1 <= $signed(rate[1]);
    end
  end

  a_clear_motor0: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op_code == OP_CLEAR) && !motor |=> (position[0] == '0) && (rate[0] == '0))
    else $error("motor 0 clear did not zero count and speed");

  a_rate0_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.rate_write && !(cmd.exec && ((op_code == OP_CLEAR) || (op_code == OP_INIT)))
    |=> $stable(rate[0]))
    else $error("motor 0 speed changed outside a speed update");

endmodule

FILE: sv/qdw_ctrl.sv
// ----------------------------------------------------------------------------
// qdw_ctrl
// Sequencer: operation accept, per-motor speed update, result publish.
// ----------------------------------------------------------------------------
module qdw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output qdw_pkg::cmd_t    cmd,
  input  qdw_pkg::status_t status
);
  import qdw_pkg::*;

  state_t state;
  state_t state_next;
  logic   sel;
  logic   sel_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    sel_next = sel;
    case (state)
      S_IDLE: begin
        sel_next = 1'b0;
        if (in_valid) begin
          state_next = (op_t'(op) == OP_TICK) ? S_MUL : S_PUB;
        end
      end
      S_MUL:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        if (sel) begin
          state_next = S_PUB;
        end else begin
          sel_next = 1'b1;
          state_next = S_MUL;
        end
      end
      S_PUB: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd = '0;
    cmd.exec = (state == S_IDLE) && in_valid;
    cmd.mul_load = (state == S_MUL);
    cmd.div_start = (state == S_START);
    cmd.rate_write = (state == S_SAT);
    cmd.sel = sel;
    cmd.publish = (state == S_PUB) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_tick_to_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op_t'(op) == OP_TICK) |=> (state == S_MUL))
    else $error("tick transaction did not start a speed update");

  a_sel_stable_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> $stable(sel))
    else $error("motor select moved during a division");

endmodule

FILE: sv/quadrature_decoder_window_speed_top.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_window_speed_top
// Two-encoder x4 quadrature decoder with rolling-window speed.
// ----------------------------------------------------------------------------
// samples carries one operation per transaction: pin sample, millisecond
// tick, clear of one motor, or init of both. results returns exactly one
// transaction per operation with both counts and both speeds after it.
// A pin sample, clear or init goes from accept to the publish state, which
// registers its result once the output register is free. A tick runs,
// for each motor, a multiply state, a divider start state, the shared
// divider (6 quotient bits a cycle over a 42-bit product) and a saturate
// state, motor 0 then motor 1, before the publish state. In both cases the
// next operation is taken only after the result has been published.
// The count history lives in one ring per motor with a valid flag per
// entry, so clear and init take effect in their accept cycle.
// Reset clears counts, speeds, pin history, ring slot and ring flags at
// once; the block is ready in the first cycle after reset.
// The result sits in an output register; a stalled receiver holds it, and
// the next operation can be accepted while it waits, but that operation's
// result is held back until the register is taken.
// ----------------------------------------------------------------------------
module quadrature_decoder_window_speed_top #(
  parameter int WINDOW = 10
) (
  input logic        clk,
  input logic        rst,
  qdw_in_if.sink     samples,
  qdw_out_if.source  results
);
  import qdw_pkg::*;

  cmd_t    cmd;
  status_t status;

  qdw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .op        (samples.op),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  qdw_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (samples.op),
    .motor        (samples.motor),
    .pins_motor0  (samples.pins_motor0),
    .pins_motor1  (samples.pins_motor1),
    .count_motor0 (results.count_motor0),
    .count_motor1 (results.count_motor1),
    .speed_motor0 (results.speed_motor0),
    .speed_motor1 (results.speed_motor1)
  );

endmodule

FILE: verif/quadrature_decoder_window_speed_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_window_speed_top_test
// Self-checking bench for the two-encoder quadrature decoder. Operation
// transactions (pin samples, ticks, clears, inits) are queued up front, a
// directed opening followed by quadrature walks with glitches, tick bursts
// and random noise. A local model of counts, pin history and the speed ring
// predicts every result, which the monitor compares field by field.
// ----------------------------------------------------------------------------
module quadrature_decoder_window_speed_top_test;
  import qdw_pkg::*;

  localparam int WINDOW = 10;
  localparam int NUM_OPS = 650;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    op_t        op;
    logic       motor;
    logic [1:0] pins0;
    logic [1:0] pins1;
    bit         drain;
  } motor_op_t;

  typedef struct packed {
    logic signed [31:0] count0;
    logic signed [31:0] count1;
    logic signed [31:0] speed0;
    logic signed [31:0] speed1;
  } motor_report_t;

  // quadrature order for forward motion
  localparam logic [1:0] QUAD_SEQ [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

  logic clk;
  logic rst;

  qdw_in_if  samples();
  qdw_out_if results();

  quadrature_decoder_window_speed_top #(.WINDOW(WINDOW)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  motor_op_t     pending_ops [$];
  motor_report_t expected_reports [$];

  logic [31:0] pos_model [2];
  logic [31:0] rate_model [2];
  logic [1:0]  last_pins [2];
  logic [31:0] count_hist [2][WINDOW];
  int          hist_slot;

  logic [1:0] walk_pins [2];
  int         issued;
  int         fails;
  int         cycles;
  bit         in_taken;
  bit         calm;
  motor_op_t  next_op;

  function automatic int quad_index(logic [1:0] p);
    int idx;
    idx = 0;
    for (int i = 0; i < 4; i++) begin
      if (QUAD_SEQ[i] == p) idx = i;
    end
    return idx;
  endfunction

  function automatic logic [31:0] quad_delta(logic [1:0] prev, logic [1:0] now);
    int d;
    d = (quad_index(now) - quad_index(prev)) & 3;
    if (d == 1) return 32'd1;
    if (d == 3) return 32'hFFFF_FFFF;
    return 32'd0;
  endfunction

  function automatic logic [31:0] window_rate(logic [31:0] now, logic [31:0] old);
    logic [31:0] diff;
    longint      q;
    diff = now - old;
    q = longint'($signed(diff)) * 1000 / WINDOW;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic void zero_motor(int m);
    pos_model[m] = '0;
    rate_model[m] = '0;
    for (int i = 0; i < WINDOW; i++) count_hist[m][i] = '0;
  endfunction

  function automatic motor_report_t apply_op(op_t op, logic motor, logic [1:0] p0,
                                             logic [1:0] p1);
    motor_report_t r;
    logic [1:0] pins [2];
    pins[0] = p0;
    pins[1] = p1;
    case (op)
      OP_SAMPLE: begin
        for (int m = 0; m < 2; m++) begin
          pos_model[m] = pos_model[m] + quad_delta(last_pins[m], pins[m]);
          last_pins[m] = pins[m];
        end
      end
      OP_TICK: begin
        for (int m = 0; m < 2; m++) begin
          rate_model[m] = window_rate(pos_model[m], count_hist[m][hist_slot]);
          count_hist[m][hist_slot] = pos_model[m];
        end
        hist_slot = (hist_slot + 1) % WINDOW;
      end
      OP_CLEAR: begin
        zero_motor(motor);
      end
      default: begin
        zero_motor(0);
        zero_motor(1);
        last_pins[0] = p0;
        last_pins[1] = p1;
        hist_slot = 0;
      end
    endcase
    r.count0 = pos_model[0];
    r.count1 = pos_model[1];
    r.speed0 = rate_model[0];
    r.speed1 = rate_model[1];
    return r;
  endfunction

  function automatic void add_op(op_t op, logic motor, logic [1:0] p0, logic [1:0] p1,
                                 bit drain = 1'b0);
    motor_op_t t;
    t.op = op;
    t.motor = motor;
    t.pins0 = p0;
    t.pins1 = p1;
    t.drain = drain;
    pending_ops.push_back(t);
    if (op == OP_SAMPLE || op == OP_INIT) begin
      walk_pins[0] = p0;
      walk_pins[1] = p1;
    end
  endfunction

  function automatic logic [1:0] walk_next(logic [1:0] cur, int dir);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return cur ^ 2'b11;
    if (r < 8) return 2'($urandom_range(0, 3));
    if (r < 20 || dir == 0) return cur;
    if (dir == 1) return QUAD_SEQ[(quad_index(cur) + 1) & 3];
    return QUAD_SEQ[(quad_index(cur) + 3) & 3];
  endfunction

  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  task automatic plan_ops();
    int kind;
    int len;
    int dir0;
    int dir1;
    int gap;
    bit drain_next;
    logic [1:0] n0;
    logic [1:0] n1;
    // directed opening
    add_op(OP_INIT, 1'b0, 2'b10, 2'b01);
    add_op(OP_SAMPLE, 1'b1, 2'b11, 2'b00);
    add_op(OP_SAMPLE, 1'b0, 2'b01, 2'b10);
    add_op(OP_SAMPLE, 1'b1, 2'b11, 2'b01);
    add_op(OP_SAMPLE, 1'b0, 2'b11, 2'b01);
    add_op(OP_SAMPLE, 1'b0, 2'b00, 2'b10);
    add_op(OP_TICK, 1'b1, 2'b11, 2'b11);
    add_op(OP_SAMPLE, 1'b1, 2'b10, 2'b11);
    add_op(OP_SAMPLE, 1'b0, 2'b11, 2'b01);
    add_op(OP_TICK, 1'b0, 2'b00, 2'b00);
    add_op(OP_SAMPLE, 1'b0, 2'b10, 2'b11);
    add_op(OP_SAMPLE, 1'b1, 2'b00, 2'b10);
    add_op(OP_TICK, 1'b0, 2'b01, 2'b10);
    add_op(OP_CLEAR, 1'b0, 2'b11, 2'b00);
    add_op(OP_TICK, 1'b1, 2'b10, 2'b01);
    add_op(OP_CLEAR, 1'b1, 2'b00, 2'b11);
    add_op(OP_SAMPLE, 1'b1, 2'b01, 2'b01);
    add_op(OP_TICK, 1'b0, 2'b11, 2'b11);
    add_op(OP_INIT, 1'b1, 2'b00, 2'b11);
    add_op(OP_SAMPLE, 1'b0, 2'b01, 2'b01);
    add_op(OP_TICK, 1'b1, 2'b00, 2'b00);
    drain_next = 1'b1;
    while (pending_ops.size() < NUM_OPS) begin
      if (pending_ops.size() > NUM_OPS / 2 && pending_ops.size() < NUM_OPS / 2 + 30)
        drain_next = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(3, 24);
        dir0 = $urandom_range(0, 2);
        dir1 = $urandom_range(0, 2);
        gap = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          n0 = walk_next(walk_pins[0], dir0);
          n1 = walk_next(walk_pins[1], dir1);
          add_op(OP_SAMPLE, 1'($urandom_range(0, 1)), n0, n1, drain_next);
          drain_next = 1'b0;
          if (i % gap == gap - 1)
            add_op(OP_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)));
        end
      end else if (kind < 80) begin
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++) begin
          add_op(OP_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), drain_next);
          drain_next = 1'b0;
        end
      end else if (kind < 90) begin
        add_op(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), drain_next);
        drain_next = 1'b0;
      end else if (kind < 96) begin
        add_op(OP_CLEAR, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
               2'($urandom_range(0, 3)), drain_next);
        drain_next = 1'b0;
      end else begin
        add_op(OP_INIT, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
               2'($urandom_range(0, 3)), drain_next);
        drain_next = 1'b0;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    samples.valid = 1'b0;
    samples.op = OP_SAMPLE;
    samples.motor = 1'b0;
    samples.pins_motor0 = 2'b00;
    samples.pins_motor1 = 2'b00;
    results.ready = 1'b0;
    for (int m = 0; m < 2; m++) begin
      zero_motor(m);
      last_pins[m] = 2'b00;
      walk_pins[m] = 2'b00;
    end
    hist_slot = 0;
    issued = 0;
    fails = 0;
    cycles = 0;
    in_taken = 1'b0;
    plan_ops();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    do @(posedge clk);
    while (pending_ops.size() != 0 || samples.valid || expected_reports.size() != 0);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("quadrature_decoder_window_speed_top: match");
    end else begin
      $display("quadrature_decoder_window_speed_top: mismatch");
    end
    $finish;
  end

  assign calm = (issued >= 300 && issued < 420);

  // driver
  always @(negedge clk) begin
    if (!rst && (!samples.valid || in_taken)) begin
      if (pending_ops.size() != 0 &&
          !(pending_ops[0].drain && expected_reports.size() != 0) &&
          (calm || $urandom_range(0, 99) >= 26)) begin
        next_op = pending_ops.pop_front();
        samples.op <= next_op.op;
        samples.motor <= next_op.motor;
        samples.pins_motor0 <= next_op.pins0;
        samples.pins_motor1 <= next_op.pins1;
        samples.valid <= 1'b1;
        issued++;
      end else begin
        samples.valid <= 1'b0;
      end
    end
    results.ready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // monitor and prediction
  always @(posedge clk) begin
    motor_report_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("quadrature_decoder_window_speed_top: mismatch");
      $finish;
    end else begin
      if (!rst) begin
        if (results.valid && results.ready) begin
          if (expected_reports.size() == 0) begin
            fails++;
            $error("result transaction with no operation pending");
          end else begin
            exp_r = expected_reports.pop_front();
            check_field("count_motor0", exp_r.count0, results.count_motor0);
            check_field("count_motor1", exp_r.count1, results.count_motor1);
            check_field("speed_motor0", exp_r.speed0, results.speed_motor0);
            check_field("speed_motor1", exp_r.speed1, results.speed_motor1);
          end
        end
        if (samples.valid && samples.ready)
          expected_reports.push_back(apply_op(op_t'(samples.op), samples.motor,
                                              samples.pins_motor0, samples.pins_motor1));
      end
      in_taken <= samples.valid && samples.ready && !rst;
    end
  end

endmodule
